// ===== hdl/tcw_pkg.sv =====
// Shared types, constants and codes for the text console writer.
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

  // Field widths of the channels.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = ATTR_W + CHAR_W;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Character and attribute constants.
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  // One result item.
  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } rsp_t;

endpackage

// ===== hdl/tcw_if.sv =====
// Channel interfaces of the text console writer: command, response and configuration.
interface tcw_cmd_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output op, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input op, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic              scrolled;

  modport source (output valid, output cell_value, output cursor_row,
                  output cursor_col, output scrolled, input ready);
  modport sink   (input valid, input cell_value, input cursor_row,
                  input cursor_col, input scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_attribute;

  modport source (output valid, output text_attribute, input ready);
  modport sink   (input valid, input text_attribute, output ready);
endinterface

// ===== hdl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tcw_engine.sv =====
// Command sequencer of the text console writer: cursor, screen sweeps and memory access.
module tcw_engine import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tcw_cmd_if.sink           cmd,
  input  logic [ATTR_W-1:0] attr,
  output rsp_t              res,
  output logic              res_valid,
  input  logic              res_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t            state;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] cnt;
  logic              sweep_copy;
  logic              init_pass;
  logic [CELL_W-1:0] sweep_blank;
  logic              p_valid;
  logic              p_copy;
  logic [ADDR_W-1:0] p_addr;
  logic [CELL_W-1:0] res_value;
  logic              res_scrolled;

  logic              accept;
  logic              is_newline;
  logic              is_return;
  logic              is_print;
  logic              idx_ok;
  logic              copy_issue;
  logic              need_scroll;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [ADDR_W-1:0] put_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign cmd.ready  = (state == S_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign is_newline = (cmd.char_code == CH_NEWLINE);
  assign is_return  = (cmd.char_code == CH_RETURN);
  assign is_print   = !is_newline && !is_return;
  assign idx_ok     = (ADDR_W'(cmd.cell_index) < ADDR_W'(CELL_COUNT));
  assign put_addr   = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  assign copy_issue = (state == S_SWEEP) && sweep_copy && (cnt < ADDR_W'(COPY_COUNT));

  // Cursor movement of a put.
  always_comb begin
    need_scroll = 1'b0;
    row_next    = row;
    col_next    = col;
    if (is_newline || (is_print && col == COL_W'(COLUMNS - 1))) begin
      col_next = '0;
      if (row == ROW_W'(ROWS - 1)) begin
        need_scroll = 1'b1;
      end else begin
        row_next = ROW_W'(row + 1'b1);
      end
    end else if (is_return) begin
      col_next = '0;
    end else begin
      col_next = COL_W'(col + 1'b1);
    end
  end

  // Memory ports: each sweep write follows its read in the next cycle.
  assign ram_we    = p_valid || (accept && cmd.op == OP_PUT && is_print);
  assign ram_waddr = p_valid ? p_addr : put_addr;
  assign ram_wdata = p_valid ? (p_copy ? ram_rdata : sweep_blank) : {attr, cmd.char_code};
  assign ram_re    = (accept && cmd.op == OP_READ && idx_ok) || copy_issue;
  assign ram_raddr = (state == S_SWEEP) ? ADDR_W'(cnt + ADDR_W'(COLUMNS))
                                        : ADDR_W'(cmd.cell_index);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      row          <= '0;
      col          <= '0;
      cnt          <= '0;
      sweep_copy   <= 1'b0;
      init_pass    <= 1'b1;
      sweep_blank  <= RESET_BLANK;
      p_valid      <= 1'b0;
      p_copy       <= 1'b0;
      p_addr       <= '0;
      res_value    <= '0;
      res_scrolled <= 1'b0;
    end else begin
      p_valid <= (state == S_SWEEP);
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_value    <= (cmd.op == OP_PUT && is_print) ? {attr, cmd.char_code} : '0;
            res_scrolled <= (cmd.op == OP_PUT) && need_scroll;
            case (cmd.op)
              OP_PUT: begin
                row <= row_next;
                col <= col_next;
                if (need_scroll) begin
                  sweep_copy   <= 1'b1;
                  sweep_blank  <= {attr, CH_SPACE};
                  init_pass    <= 1'b0;
                  cnt          <= '0;
                  state        <= S_SWEEP;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_READ: begin
                state <= idx_ok ? S_READ : S_DONE;
              end
              OP_CLEAR: begin
                row         <= '0;
                col         <= '0;
                sweep_copy  <= 1'b0;
                sweep_blank <= {attr, CH_SPACE};
                init_pass   <= 1'b0;
                cnt         <= '0;
                state       <= S_SWEEP;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          res_value <= ram_rdata;
          state     <= S_DONE;
        end
        S_SWEEP: begin
          p_addr  <= cnt;
          p_copy  <= copy_issue;
          if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
            state <= S_DRAIN;
          end else begin
            cnt <= ADDR_W'(cnt + 1'b1);
          end
        end
        S_DRAIN: begin
          state <= init_pass ? S_IDLE : S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid      = (state == S_DONE);
  assign res.cell_value = res_value;
  assign res.cursor_row = row;
  assign res.cursor_col = col;
  assign res.scrolled   = res_scrolled;

endmodule

// ===== hdl/text_console_writer.sv =====
// Top level of the text console writer: attribute register, engine and response register.
//
//   Channel  Direction  Payload                                           Transfer when
//   cmd      in         op, char_code, cell_index                         valid & ready
//   rsp      out        cell_value, cursor_row, cursor_col, scrolled      valid & ready
//   cfg      in         text_attribute                                    valid & ready
//
// A put of a printable byte, carriage return or newline that does not scroll, an unused op
// and a read past the end of the screen go straight from idle to done; a read of a cell on
// the screen passes through a read state first. A put that scrolls and a clear each sweep
// the whole screen memory once, one cell per cycle through its read and its write port.
// After reset the screen memory is filled with blanks of attribute 0x0F, one cell per
// cycle; no command is taken during that pass.
// The response sits in an output register, so the engine takes the next command while a
// finished response still waits on a stalled rsp channel.
module text_console_writer import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tcw_cmd_if.sink   cmd,
  tcw_rsp_if.source rsp,
  tcw_cfg_if.sink   cfg
);

  logic [ATTR_W-1:0] attr;
  rsp_t              res;
  logic              res_valid;
  logic              res_ready;
  rsp_t              rsp_data;
  logic              rsp_valid;

  // Attribute register always ready; user writes only while idle, not enforced by block.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (cfg.valid && cfg.ready) begin
      attr <= cfg.text_attribute;
    end
  end

  // The engine owns the cursor and the screen memory.
  tcw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .attr      (attr),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  // Output register: loads when empty or when its current response is taken.
  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.cell_value = rsp_data.cell_value;
  assign rsp.cursor_row = rsp_data.cursor_row;
  assign rsp.cursor_col = rsp_data.cursor_col;
  assign rsp.scrolled   = rsp_data.scrolled;

endmodule
